// ===== design/sorted_id_set_assert.svh =====
// Assertion macros for the sorted identifier set checker
`ifndef SORTED_ID_SET_ASSERT_SVH
`define SORTED_ID_SET_ASSERT_SVH

// same-cycle implication
`define SIS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SIS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sis_pkg.sv =====
// Types and codes shared by the sorted identifier set
package sis_pkg;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_NOTIFY = 2'd2,
		ACT_CANCEL = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_ADD,
		S_ADD_PUT,
		S_RM_FIND,
		S_RM_SHIFT,
		S_FLUSH,
		S_RES
	} state_t;

	localparam int ID_W  = 32;
	localparam int ERR_W = 32;
	localparam int POS_W = 5;
	localparam int CNT_OUT_W = 6;

endpackage

// ===== design/sorted_id_set.sv =====
// Sequence: add decodes, then moves each larger entry up one slot (a full or empty table
// goes straight to the result); remove decodes, searches entry by entry, then moves any later
// entries down; flush gives one item per cycle unless the output stalls. One item at
// a time: the next is taken once the sequencer is idle again after the last result loads.
// Reset clears the count, the sequencer and the output valid; the store is not
// cleared, as only entries below the count are ever read.
module sorted_id_set import sis_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              action,
	input  logic [ID_W-1:0]         req_id,
	input  logic signed [ERR_W-1:0] error_code,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic [ID_W-1:0]         out_id,
	output logic [POS_W-1:0]        position,
	output logic [CNT_OUT_W-1:0]    entry_count,
	output logic signed [ERR_W-1:0] reported_error,
	output logic                    last
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	action_t          act_q;
	logic [ID_W-1:0]  id_q;
	logic [ERR_W-1:0] err_q;

	logic [IDX_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	status_t          res_status_q, res_status_d;
	logic [ID_W-1:0]  res_id_q, res_id_d;
	logic [IDX_W-1:0] res_pos_q, res_pos_d;
	logic [CNT_W-1:0] res_cnt_q, res_cnt_d;
	logic [ERR_W-1:0] res_err_q, res_err_d;

	logic             out_valid_q;
	status_t          out_status_q, out_status_d;
	logic [ID_W-1:0]  out_id_q, out_id_d;
	logic [IDX_W-1:0] out_pos_q, out_pos_d;
	logic [CNT_W-1:0] out_cnt_q, out_cnt_d;
	logic [ERR_W-1:0] out_err_q, out_err_d;
	logic             out_last_q, out_last_d;
	logic             out_load;
	logic             out_free;

	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_waddr, mem_raddr;
	logic [ID_W-1:0]  mem_wdata, mem_rdata;

	logic [CNT_W-1:0] pos_ext, pos_inc, pos_inc2;
	logic [ERR_W-1:0] rep;
	logic             rd_gt, rd_eq;
	logic             in_acc;

	sis_mem #(
		.DEPTH (CAPACITY),
		.AW    (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// comparators of the store's read data against the request id
	assign rd_gt = (mem_rdata > id_q);
	assign rd_eq = (mem_rdata == id_q);

	assign pos_ext  = CNT_W'(pos_q);
	assign pos_inc  = pos_ext + CNT_W'(1);
	assign pos_inc2 = pos_ext + CNT_W'(2);
	assign rep      = (act_q == ACT_NOTIFY) ? err_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q <= action_t'(action);
			id_q  <= req_id;
			err_q <= error_code;
		end
		pos_q        <= pos_d;
		res_status_q <= res_status_d;
		res_id_q     <= res_id_d;
		res_pos_q    <= res_pos_d;
		res_cnt_q    <= res_cnt_d;
		res_err_q    <= res_err_d;
		if (out_load) begin
			out_status_q <= out_status_d;
			out_id_q     <= out_id_d;
			out_pos_q    <= out_pos_d;
			out_cnt_q    <= out_cnt_d;
			out_err_q    <= out_err_d;
			out_last_q   <= out_last_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		pos_d        = pos_q;
		cnt_d        = cnt_q;
		res_status_d = res_status_q;
		res_id_d     = res_id_q;
		res_pos_d    = res_pos_q;
		res_cnt_d    = res_cnt_q;
		res_err_d    = res_err_q;
		mem_we       = 1'b0;
		mem_waddr    = '0;
		mem_wdata    = id_q;
		mem_re       = 1'b0;
		mem_raddr    = '0;
		out_load     = 1'b0;
		out_status_d = res_status_q;
		out_id_d     = res_id_q;
		out_pos_d    = res_pos_q;
		out_cnt_d    = res_cnt_q;
		out_err_d    = res_err_q;
		out_last_d   = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				res_id_d  = id_q;
				res_pos_d = '0;
				res_err_d = '0;
				unique case (act_q)
					ACT_ADD: begin
						if (cnt_q == CNT_W'(CAPACITY)) begin
							res_status_d = STAT_FULL;
							res_cnt_d    = cnt_q;
							state_d      = S_RES;
						end else if (cnt_q == '0) begin
							mem_we       = 1'b1;
							cnt_d        = CNT_W'(1);
							res_status_d = STAT_OK;
							res_cnt_d    = CNT_W'(1);
							state_d      = S_RES;
						end else begin
							pos_d     = IDX_W'(cnt_q);
							mem_re    = 1'b1;
							mem_raddr = IDX_W'(cnt_q - CNT_W'(1));
							state_d   = S_ADD;
						end
					end
					ACT_REMOVE: begin
						if (cnt_q == '0) begin
							res_status_d = STAT_EMPTY;
							res_cnt_d    = '0;
							state_d      = S_RES;
						end else begin
							pos_d   = '0;
							mem_re  = 1'b1;
							state_d = S_RM_FIND;
						end
					end
					ACT_NOTIFY, ACT_CANCEL: begin
						if (cnt_q == '0) begin
							res_status_d = STAT_EMPTY;
							res_id_d     = '0;
							res_cnt_d    = '0;
							res_err_d    = rep;
							state_d      = S_RES;
						end else begin
							pos_d   = '0;
							mem_re  = 1'b1;
							state_d = S_FLUSH;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_ADD: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				if (rd_gt) begin
					mem_wdata = mem_rdata;
					pos_d     = pos_q - IDX_W'(1);
					if (pos_q == IDX_W'(1)) begin
						state_d = S_ADD_PUT;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = IDX_W'(pos_ext - CNT_W'(2));
					end
				end else begin
					cnt_d        = cnt_q + CNT_W'(1);
					res_status_d = STAT_OK;
					res_pos_d    = pos_q;
					res_cnt_d    = cnt_q + CNT_W'(1);
					state_d      = S_RES;
				end
			end
			S_ADD_PUT: begin
				mem_we       = 1'b1;
				mem_waddr    = '0;
				cnt_d        = cnt_q + CNT_W'(1);
				res_status_d = STAT_OK;
				res_pos_d    = '0;
				res_cnt_d    = cnt_q + CNT_W'(1);
				state_d      = S_RES;
			end
			S_RM_FIND: begin
				if (rd_eq) begin
					res_pos_d = pos_q;
					if (pos_inc == cnt_q) begin
						cnt_d        = cnt_q - CNT_W'(1);
						res_status_d = STAT_OK;
						res_cnt_d    = cnt_q - CNT_W'(1);
						state_d      = S_RES;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = IDX_W'(pos_inc);
						state_d   = S_RM_SHIFT;
					end
				end else if (pos_inc == cnt_q) begin
					res_status_d = STAT_NOT_FOUND;
					res_cnt_d    = cnt_q;
					state_d      = S_RES;
				end else begin
					pos_d     = IDX_W'(pos_inc);
					mem_re    = 1'b1;
					mem_raddr = IDX_W'(pos_inc);
				end
			end
			S_RM_SHIFT: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = mem_rdata;
				pos_d     = IDX_W'(pos_inc);
				if (pos_inc2 < cnt_q) begin
					mem_re    = 1'b1;
					mem_raddr = IDX_W'(pos_inc2);
				end else begin
					cnt_d        = cnt_q - CNT_W'(1);
					res_status_d = STAT_OK;
					res_cnt_d    = cnt_q - CNT_W'(1);
					state_d      = S_RES;
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_status_d = STAT_OK;
					out_id_d     = mem_rdata;
					out_pos_d    = pos_q;
					out_cnt_d    = cnt_q - pos_inc;
					out_err_d    = rep;
					out_last_d   = (pos_inc == cnt_q);
					if (pos_inc == cnt_q) begin
						cnt_d   = '0;
						state_d = S_IDLE;
					end else begin
						pos_d     = IDX_W'(pos_inc);
						mem_re    = 1'b1;
						mem_raddr = IDX_W'(pos_inc);
					end
				end
			end
			S_RES: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign out_id         = out_id_q;
	assign position       = POS_W'(out_pos_q);
	assign entry_count    = CNT_OUT_W'(out_cnt_q);
	assign reported_error = out_err_q;
	assign last           = out_last_q;

endmodule

// ===== design/sis_mem.sv =====
// Entry store: one write port, one read port with registered data
module sis_mem import sis_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  logic [ID_W-1:0] wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output logic [ID_W-1:0] rdata
);

	logic [ID_W-1:0] mem_q [DEPTH];
	logic [ID_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/sis_checker.sv =====
// Port-level checker for the sorted identifier set, with its bind
`include "sorted_id_set_assert.svh"

module sis_checker import sis_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [1:0]              status,
	input logic [ID_W-1:0]         out_id,
	input logic [CNT_OUT_W-1:0]    entry_count,
	input logic                    last
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] cap_cnt;
	assign cap_cnt = CNT_W'(CAPACITY);

	`SIS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
		"block took a second item straight after the first")

	`SIS_ASSERT_NOW(a_mid_flush_ok, out_valid && !last,
		(status == STAT_OK) && (entry_count != '0),
		"non-final item of a flush is not an ok entry")

	`SIS_ASSERT_NOW(a_count_bound, out_valid && (CNT_W <= CNT_OUT_W),
		CNT_W'(entry_count) <= cap_cnt, "entry count above capacity")

	`SIS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(out_id) && $stable(status) && $stable(last),
		"stalled output item changed")

endmodule

bind sorted_id_set sis_checker #(.CAPACITY(CAPACITY)) u_sis_checker (.*);
